// ----- src/b58e_pkg.sv -----
// ----------------------------------------------------------------------------
// b58e_pkg
// Shared types, constants and the character table of the base58 encoder.
// ----------------------------------------------------------------------------
package b58e_pkg;

   typedef logic [5:0] digit_type;
   typedef logic [7:0] char_type;

   localparam int B58_RADIX          = 58;
   // floor(x / 58) == (x * 2260) >> 17 for every x below 58 * 256
   localparam int B58_RECIP          = 2260;
   localparam int B58_RECIP_SHIFT    = 17;
   localparam int MAX_OUT            = 44;
   localparam int OUTPUT_LIMIT_RESET = 255;
   localparam int TEXT_LENGTH_W      = 6;

   localparam char_type CHAR_ONE = "1";
   localparam char_type CHAR_NUL = 8'h00;

   localparam char_type ALPHABET [B58_RADIX] = '{
      "1", "2", "3", "4", "5", "6", "7", "8", "9",
      "A", "B", "C", "D", "E", "F", "G", "H", "J", "K", "L", "M", "N",
      "P", "Q", "R", "S", "T", "U", "V", "W", "X", "Y", "Z",
      "a", "b", "c", "d", "e", "f", "g", "h", "i", "j", "k",
      "m", "n", "o", "p", "q", "r", "s", "t", "u", "v", "w", "x", "y", "z"
   };

   function automatic char_type b58_char(digit_type d);
      char_type c;
      c = CHAR_ONE;
      if (d < digit_type'(B58_RADIX)) begin
         c = ALPHABET[d];
      end
      return c;
   endfunction

endpackage

// ----- src/b58e_ram.sv -----
// ----------------------------------------------------------------------------
// b58e_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module b58e_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 44,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/b58e_digit_step.sv -----
// ----------------------------------------------------------------------------
// b58e_digit_step
// One digit of the multiply-by-256 fold: x = 256 * digit + carry,
// new digit = x mod 58, new carry = x / 58.
// ----------------------------------------------------------------------------
module b58e_digit_step
   import b58e_pkg::*;
(
   input  digit_type  cur_digit,
   input  logic [7:0] cur_carry,
   output digit_type  new_digit,
   output logic [7:0] new_carry
);

   localparam int XW = 14;
   localparam int PW = XW + 12;

   logic [XW-1:0] x;
   logic [PW-1:0] prod;
   logic [PW-1:0] quot_w;
   logic [7:0]    quot;
   logic [XW-1:0] rem_w;

   always_comb begin
      x      = {cur_digit, 8'h00} + XW'(cur_carry);
      prod   = PW'(x) * PW'(B58_RECIP);
      quot_w = prod >> B58_RECIP_SHIFT;
      quot   = quot_w[7:0];
      rem_w  = x - XW'(quot) * XW'(B58_RADIX);
   end

   assign new_digit = rem_w[5:0];
   assign new_carry = quot;

endmodule

// ----- src/base58_encoder.sv -----
// ----------------------------------------------------------------------------
// base58_encoder
// Base58 (bitcoin alphabet) encoder: bytes in, characters out.
// ----------------------------------------------------------------------------
// Input: a leading zero byte or an ignored byte is taken in the idle state; any
//   other byte also runs the fold state, one stored digit per cycle through the
//   digit RAM read-modify-write loop.
// Last byte: a finish state, then one character per cycle while the output is
//   not stalled, with a RAM read state before the first significant digit.
// Reset: synchronous; clears counters and flags. The digit RAM is not cleared:
//   entries at or above digits_in_use read as zero, so no clearing pass runs.
// ----------------------------------------------------------------------------
module base58_encoder
   import b58e_pkg::*;
#(
   parameter int MAX_BYTES = 32
) (
   input  logic       clock,
   input  logic       reset,
   // input words
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_is_last,
   // result words
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_char_out,
   output logic       rsp_end_of_text,
   output logic       rsp_failed,
   output logic [5:0] rsp_text_length,
   // output_limit register
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   localparam int DigitDepth = 1 + (MAX_BYTES * 1366) / 1000;
   localparam int AddrW      = $clog2(DigitDepth);
   localparam int DiuW       = $clog2(DigitDepth + 1);
   localparam int ZcW        = $clog2(MAX_BYTES + 1);
   localparam int BsW        = $clog2(MAX_BYTES + 2);
   localparam int TotW       = ((ZcW > DiuW) ? ZcW : DiuW) + 1;
   localparam int CmpW       = ((TotW > 8) ? TotW : 8) + 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_FOLD = 3'd1;
   localparam logic [2:0] ST_FIN  = 3'd2;
   localparam logic [2:0] ST_ZERO = 3'd3;
   localparam logic [2:0] ST_DRD  = 3'd4;
   localparam logic [2:0] ST_DOUT = 3'd5;

   // control state
   logic [2:0]      state_ff, state_in;
   logic [DiuW-1:0] diu_ff, diu_in;
   logic [ZcW-1:0]  zc_ff, zc_in;
   logic            ilz_ff, ilz_in;
   logic [BsW-1:0]  bytes_ff, bytes_in;
   logic            ovf_ff, ovf_in;
   logic [7:0]      limit_ff;
   logic            rsp_valid_ff;
   // working registers
   logic            last_ff, last_in;
   logic [7:0]      carry_ff, carry_in;
   logic [DiuW-1:0] idx_ff, idx_in;
   logic [ZcW-1:0]  zrem_ff, zrem_in;
   logic [DiuW-1:0] drem_ff, drem_in;
   logic [TotW-1:0] total_ff, total_in;
   logic [7:0]      rsp_char_ff;
   logic            rsp_eot_ff;
   logic            rsp_failed_ff;
   logic [5:0]      rsp_len_ff;

   // RAM ports
   logic             rd_en, wr_en;
   logic [AddrW-1:0] rd_addr, wr_addr;
   digit_type        rd_data, wr_data;

   // fold datapath
   digit_type  step_digit_in;
   digit_type  step_digit;
   logic [7:0] step_carry;

   // output load
   logic       out_free;
   logic       out_load;
   char_type   out_char;
   logic       out_eot;
   logic       out_failed;
   logic [5:0] out_len;

   logic            fold_go;
   logic            ovf_next;
   logic            fin_fail;
   logic [TotW-1:0] total_now;
   logic [DiuW-1:0] idx_plus;
   logic [DiuW-1:0] drem_m1;
   logic [DiuW-1:0] drem_m2;

   b58e_ram #(
      .WIDTH (6),
      .DEPTH (DigitDepth)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   b58e_digit_step u_step (
      .cur_digit (step_digit_in),
      .cur_carry (carry_ff),
      .new_digit (step_digit),
      .new_carry (step_carry)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      // digits at or above the fill count are zero
      step_digit_in = (idx_ff < diu_ff) ? rd_data : digit_type'(0);
      fold_go       = (idx_ff < DiuW'(DigitDepth)) && ((carry_ff != 8'd0) || (idx_ff < diu_ff));
      idx_plus      = idx_ff + DiuW'(1);
      drem_m1       = drem_ff - DiuW'(1);
      drem_m2       = drem_ff - DiuW'(2);
      total_now     = TotW'(zc_ff) + TotW'(diu_ff);
      fin_fail      = ovf_ff
                      || (CmpW'(total_now) >= CmpW'(limit_ff))
                      || (CmpW'(total_now) > CmpW'(MAX_OUT));
      ovf_next      = ovf_ff || (bytes_ff >= BsW'(MAX_BYTES));
   end

   always_comb begin
      state_in   = state_ff;
      diu_in     = diu_ff;
      zc_in      = zc_ff;
      ilz_in     = ilz_ff;
      bytes_in   = bytes_ff;
      ovf_in     = ovf_ff;
      last_in    = last_ff;
      carry_in   = carry_ff;
      idx_in     = idx_ff;
      zrem_in    = zrem_ff;
      drem_in    = drem_ff;
      total_in   = total_ff;
      rd_en      = 1'b0;
      rd_addr    = '0;
      wr_en      = 1'b0;
      wr_addr    = idx_ff[AddrW-1:0];
      wr_data    = step_digit;
      out_load   = 1'b0;
      out_char   = CHAR_NUL;
      out_eot    = 1'b0;
      out_failed = 1'b0;
      out_len    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               last_in = req_is_last;
               if (bytes_ff != BsW'(MAX_BYTES + 1)) begin
                  bytes_in = bytes_ff + BsW'(1);
               end
               ovf_in   = ovf_next;
               state_in = req_is_last ? ST_FIN : ST_IDLE;
               if (!ovf_next) begin
                  if (ilz_ff && (req_data_byte == 8'd0)) begin
                     zc_in = zc_ff + ZcW'(1);
                  end else begin
                     ilz_in   = 1'b0;
                     carry_in = req_data_byte;
                     idx_in   = '0;
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = ST_FOLD;
                  end
               end
            end
         end

         ST_FOLD: begin
            if (fold_go) begin
               wr_en    = 1'b1;
               carry_in = step_carry;
               idx_in   = idx_plus;
               // prefetch the next digit while this one is written back
               if (idx_plus < DiuW'(DigitDepth)) begin
                  rd_en   = 1'b1;
                  rd_addr = idx_plus[AddrW-1:0];
               end
            end else begin
               diu_in = idx_ff;
               if (carry_ff != 8'd0) begin
                  ovf_in = 1'b1;
               end
               state_in = last_ff ? ST_FIN : ST_IDLE;
            end
         end

         ST_FIN: begin
            if (!fin_fail || out_free) begin
               diu_in   = '0;
               zc_in    = '0;
               ilz_in   = 1'b1;
               bytes_in = '0;
               ovf_in   = 1'b0;
            end
            if (fin_fail) begin
               if (out_free) begin
                  out_load   = 1'b1;
                  out_eot    = 1'b1;
                  out_failed = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               zrem_in  = zc_ff;
               drem_in  = diu_ff;
               total_in = total_now;
               if (zc_ff != '0) begin
                  state_in = ST_ZERO;
               end else if (diu_ff != '0) begin
                  state_in = ST_DRD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_ZERO: begin
            if (out_free) begin
               out_load = 1'b1;
               out_char = CHAR_ONE;
               zrem_in  = zrem_ff - ZcW'(1);
               if (zrem_ff == ZcW'(1)) begin
                  if (drem_ff != '0) begin
                     state_in = ST_DRD;
                  end else begin
                     out_eot  = 1'b1;
                     out_len  = 6'(total_ff);
                     state_in = ST_IDLE;
                  end
               end
            end
         end

         ST_DRD: begin
            rd_en    = 1'b1;
            rd_addr  = drem_m1[AddrW-1:0];
            state_in = ST_DOUT;
         end

         ST_DOUT: begin
            // read data holds while the output is stalled
            if (out_free) begin
               out_load = 1'b1;
               out_char = b58_char(rd_data);
               drem_in  = drem_m1;
               if (drem_ff == DiuW'(1)) begin
                  out_eot  = 1'b1;
                  out_len  = 6'(total_ff);
                  state_in = ST_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = drem_m2[AddrW-1:0];
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         diu_ff       <= '0;
         zc_ff        <= '0;
         ilz_ff       <= 1'b1;
         bytes_ff     <= '0;
         ovf_ff       <= 1'b0;
         limit_ff     <= 8'(OUTPUT_LIMIT_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         diu_ff   <= diu_in;
         zc_ff    <= zc_in;
         ilz_ff   <= ilz_in;
         bytes_ff <= bytes_in;
         ovf_ff   <= ovf_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      last_ff  <= last_in;
      carry_ff <= carry_in;
      idx_ff   <= idx_in;
      zrem_ff  <= zrem_in;
      drem_ff  <= drem_in;
      total_ff <= total_in;
      if (out_load) begin
         rsp_char_ff   <= out_char;
         rsp_eot_ff    <= out_eot;
         rsp_failed_ff <= out_failed;
         rsp_len_ff    <= out_len;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_char_out    = rsp_char_ff;
   assign rsp_end_of_text = rsp_eot_ff;
   assign rsp_failed      = rsp_failed_ff;
   assign rsp_text_length = rsp_len_ff;

   // write-back and prefetch never hit the same digit
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("digit RAM read and write at the same address");

   // writes stay inside the digit store
   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (DiuW'(wr_addr) < DiuW'(DigitDepth)))
      else $error("digit RAM write out of range");

   // the fill count never passes the depth
   a_diu_bound: assert property (@(posedge clock) disable iff (reset)
      diu_ff <= DiuW'(DigitDepth))
      else $error("digits_in_use above depth");

   // an error word is always a lone, empty end-of-text word
   a_error_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_failed) |->
         (rsp_end_of_text && (rsp_text_length == 6'd0) && (rsp_char_out == CHAR_NUL)))
      else $error("malformed error word");

endmodule

// ----- test/tb_base58_encoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_base58_encoder
// Feeds byte messages into the base58 encoder and compares every character
// word against a local big-number model. A short directed table comes first,
// then random messages under several output limits, with random idle
// gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_base58_encoder
   import b58e_pkg::*;
();

   localparam int MAX_BYTES     = 32;
   localparam int DIGIT_DEPTH   = 1 + (MAX_BYTES * 1366) / 1000;
   localparam int TEXT_MAX      = 44;
   localparam int SETTLE_CYCLES = 60;
   localparam int DRAIN_CYCLES  = 100;
   localparam string B58_DIGITS =
      "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

   typedef struct packed {
      char_type    ch;
      logic        eot;
      logic        fail;
      logic [5:0]  len;
   } char_word_type;

   typedef enum logic {ROW_BYTES, ROW_LIMIT} row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      logic [7:0]    value;   // data byte, or limit for a register row
      logic          last;
      logic [5:0]    rep;     // byte repeated, is_last only on the final copy
      logic          typed;
      char_word_type want;
   } stim_row_type;

   localparam char_word_type FAIL_WORD = '{CHAR_NUL, 1'b1, 1'b1, 6'd0};
   localparam char_word_type NO_WORD   = '{8'h00, 1'b0, 1'b0, 6'd0};
   localparam int N_ROWS = 17;

   localparam stim_row_type DIRECTED_ROWS [N_ROWS] = '{
      '{ROW_BYTES, 8'h00, 1'b1, 6'd1,  1'b1, '{"1", 1'b1, 1'b0, 6'd1}},
      '{ROW_BYTES, 8'h01, 1'b1, 6'd1,  1'b1, '{"2", 1'b1, 1'b0, 6'd1}},
      '{ROW_BYTES, 8'h39, 1'b1, 6'd1,  1'b1, '{"z", 1'b1, 1'b0, 6'd1}},
      '{ROW_BYTES, 8'hFF, 1'b1, 6'd1,  1'b0, NO_WORD},
      '{ROW_BYTES, 8'h00, 1'b0, 6'd2,  1'b0, NO_WORD},
      '{ROW_BYTES, 8'h80, 1'b0, 6'd1,  1'b0, NO_WORD},
      '{ROW_BYTES, 8'h00, 1'b1, 6'd1,  1'b0, NO_WORD},
      // one byte past the input limit
      '{ROW_BYTES, 8'hA5, 1'b1, 6'd33, 1'b1, FAIL_WORD},
      '{ROW_BYTES, 8'h5A, 1'b0, 6'd1,  1'b0, NO_WORD},
      '{ROW_BYTES, 8'hC3, 1'b1, 6'd1,  1'b0, NO_WORD},
      // limit 1 leaves room for the terminator only
      '{ROW_LIMIT, 8'd1,  1'b0, 6'd1,  1'b0, NO_WORD},
      '{ROW_BYTES, 8'h01, 1'b1, 6'd1,  1'b1, FAIL_WORD},
      '{ROW_BYTES, 8'h00, 1'b1, 6'd1,  1'b1, FAIL_WORD},
      '{ROW_LIMIT, 8'd2,  1'b0, 6'd1,  1'b0, NO_WORD},
      '{ROW_BYTES, 8'h00, 1'b1, 6'd1,  1'b1, '{"1", 1'b1, 1'b0, 6'd1}},
      '{ROW_BYTES, 8'hFF, 1'b1, 6'd1,  1'b1, FAIL_WORD},
      '{ROW_LIMIT, 8'd255, 1'b0, 6'd1, 1'b0, NO_WORD}
   };

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_data_byte;
   logic       req_is_last;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_char_out;
   logic       rsp_end_of_text;
   logic       rsp_failed;
   logic [5:0] rsp_text_length;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   // encoder model state
   digit_type  num_digits [DIGIT_DEPTH];  // index 0 least significant
   int         digits_used;
   int         lead_zeros;
   bit         in_lead;
   int         byte_cnt;
   bit         too_long;
   int         limit_reg;

   char_word_type pending_chars [$];
   int            pushed_cnt;     // words queued by the most recent byte
   int            mismatch_cnt;
   int            stall_left;
   bit            quiet;

   base58_encoder #(
      .MAX_BYTES(MAX_BYTES)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_is_last     (req_is_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_char_out    (rsp_char_out),
      .rsp_end_of_text (rsp_end_of_text),
      .rsp_failed      (rsp_failed),
      .rsp_text_length (rsp_text_length),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("[base58_encoder] ERROR");
      $finish;
   end

   function automatic void clear_message();
      for (int i = 0; i < DIGIT_DEPTH; i++) begin
         num_digits[i] = '0;
      end
      digits_used = 0;
      lead_zeros  = 0;
      in_lead     = 1'b1;
      byte_cnt    = 0;
      too_long    = 1'b0;
   endfunction

   // One accepted byte: update the model, queue the characters it releases.
   function automatic void predict_byte(logic [7:0] b, logic last);
      int carry;
      int i;
      int sig;
      int total;
      char_word_type w;
      if (byte_cnt < 255) byte_cnt++;
      if (byte_cnt > MAX_BYTES) too_long = 1'b1;
      if (!too_long) begin
         if (in_lead && b == 8'h00) begin
            if (lead_zeros < 255) lead_zeros++;
         end else begin
            in_lead = 1'b0;
            carry = int'(b);
            i = 0;
            while (i < DIGIT_DEPTH && (carry != 0 || i < digits_used)) begin
               carry = carry + 256 * int'(num_digits[i]);
               num_digits[i] = digit_type'(carry % 58);
               carry = carry / 58;
               i++;
            end
            if (carry != 0) too_long = 1'b1;
            digits_used = i;
         end
      end
      if (!last) return;
      sig = (digits_used > DIGIT_DEPTH) ? DIGIT_DEPTH : digits_used;
      while (sig > 0 && num_digits[sig - 1] == 0) sig--;
      total = lead_zeros + sig;
      if (too_long || total + 1 > limit_reg || total > TEXT_MAX) begin
         pending_chars.push_back(FAIL_WORD);
      end else begin
         for (i = 0; i < total; i++) begin
            w.ch   = (i < lead_zeros) ? char_type'("1")
                   : char_type'(B58_DIGITS[num_digits[total - 1 - i]]);
            w.eot  = (i == total - 1);
            w.fail = 1'b0;
            w.len  = (i == total - 1) ? 6'(total) : 6'd0;
            pending_chars.push_back(w);
         end
      end
      clear_message();
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] rand_byte();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void flag_error(string msg);
      mismatch_cnt++;
      if (mismatch_cnt <= 10) $display("%t mismatch: %s", $realtime, msg);
   endfunction

   task automatic send_word(input logic [7:0] b, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_is_last   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pushed_cnt = pending_chars.size();
      predict_byte(b, last);
      pushed_cnt = pending_chars.size() - pushed_cnt;
   endtask

   task automatic set_limit(input logic [7:0] v);
      req_valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_reg = int'(v);
   endtask

   task automatic send_random_message(output int n);
      int kind;
      int lead;
      int k;
      bit all_ff;
      logic [7:0] b;
      kind   = $urandom_range(0, 99);
      lead   = 0;
      all_ff = 1'b0;
      if (kind < 50) begin
         n = $urandom_range(1, 6);
      end else if (kind < 70) begin
         n = $urandom_range(7, 20);
      end else if (kind < 78) begin
         n = MAX_BYTES;               // longest accepted message
         all_ff = $urandom_range(0, 1);
      end else if (kind < 85) begin
         n = $urandom_range(1, MAX_BYTES);
         lead = n - $urandom_range(0, 1);
      end else if (kind < 92) begin
         n = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 8);
      end else begin
         n = $urandom_range(21, MAX_BYTES - 1);
      end
      if (kind < 70 && $urandom_range(0, 3) == 0) lead = $urandom_range(1, n);
      for (k = 0; k < n; k++) begin
         if (k < lead) b = 8'h00;
         else if (all_ff) b = 8'hFF;
         else b = rand_byte();
         send_word(b, k == n - 1);
      end
   endtask

   // result side: runs of ready and runs of stall
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
         rsp_stall  <= 1'b0;
         stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_stall  <= 1'b1;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                   : $urandom_range(0, 3);
      end
   end

   always @(posedge clock) begin
      char_word_type got;
      char_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_char_out, rsp_end_of_text, rsp_failed, rsp_text_length};
         if (pending_chars.size() == 0) begin
            flag_error($sformatf("unexpected word char=%h eot=%b fail=%b len=%0d",
                       got.ch, got.eot, got.fail, got.len));
         end else begin
            want = pending_chars.pop_front();
            if (got.ch !== want.ch || got.eot !== want.eot ||
                got.fail !== want.fail || got.len !== want.len) begin
               flag_error($sformatf(
                  "exp char=%h eot=%b fail=%b len=%0d, got char=%h eot=%b fail=%b len=%0d",
                  want.ch, want.eot, want.fail, want.len,
                  got.ch, got.eot, got.fail, got.len));
            end
         end
      end
   end

   initial begin
      stim_row_type row;
      int ph;
      int cnt;
      int n;
      logic [7:0] lim;
      mismatch_cnt = 0;
      pushed_cnt   = 0;
      stall_left   = 0;
      quiet        = 1'b0;
      limit_reg    = OUTPUT_LIMIT_RESET;
      clear_message();
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data_byte <= 8'h00;
      req_is_last   <= 1'b0;
      rsp_stall     <= 1'b0;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= 8'h00;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < N_ROWS; r++) begin
         row = DIRECTED_ROWS[r];
         if (row.kind == ROW_LIMIT) begin
            set_limit(row.value);
         end else begin
            for (int k = 0; k < int'(row.rep); k++) begin
               send_word(row.value, row.last && k == int'(row.rep) - 1);
            end
            if (row.typed) begin
               repeat (pushed_cnt) void'(pending_chars.pop_back());
               pending_chars.push_back(row.want);
            end
         end
      end

      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0: lim = 8'd45;   // exactly room for the widest text
            1: lim = 8'd44;
            2: lim = 8'($urandom_range(2, 12));
            3: lim = 8'd1;
            4: lim = 8'($urandom_range(13, 254));
            default: lim = 8'd255;
         endcase
         quiet = (ph == 2) || ($urandom_range(0, 4) == 0);
         set_limit(lim);
         cnt = 0;
         while (cnt < 40) begin
            send_random_message(n);
            cnt += n;
         end
      end
      quiet = 1'b0;

      req_valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_cnt == 0 && pending_chars.size() == 0) begin
         $display("[base58_encoder] OK");
      end else begin
         $display("[base58_encoder] ERROR");
      end
      $finish;
   end

endmodule

// ----- base58_encoder.f -----
src/b58e_pkg.sv
src/b58e_ram.sv
src/b58e_digit_step.sv
src/base58_encoder.sv
test/tb_base58_encoder.sv
